// ===== src/btc_pkg.sv =====
// Package: types and constants shared by the backlight timeout controller.
`timescale 1ns / 1ps

package btc_pkg;

  localparam int unsigned TimeoutW = 31;
  localparam int unsigned LevelW   = 7;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ReqW     = 8;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [15:0] TimeoutTicks = 16'h0787;
  localparam logic [3:0]  TickMs       = 4'd8;
  localparam logic [TimeoutW-1:0] TimeoutReset = TimeoutW'(TimeoutTicks * TickMs);
  localparam logic [LevelW-1:0]   LevelMinReset     = 7'd1;
  localparam logic [LevelW-1:0]   LevelMaxReset     = 7'd100;
  localparam logic [LevelW-1:0]   LevelDefaultReset = 7'd100;

  typedef enum logic [2:0] {
    ACT_TICK     = 3'd0,
    ACT_ACTIVITY = 3'd1,
    ACT_FORCE    = 3'd2,
    ACT_RELEASE  = 3'd3,
    ACT_ALWAYS   = 3'd4,
    ACT_LEVEL    = 3'd5
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIMEOUT       = 2'd0,
    CFG_LEVEL_MIN     = 2'd1,
    CFG_LEVEL_MAX     = 2'd2,
    CFG_LEVEL_DEFAULT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeoutW-1:0] timeout;
    logic [LevelW-1:0]   level_min;
    logic [LevelW-1:0]   level_max;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]  deadline;
    logic              armed;
    logic              lit;
    logic              forced;
    logic              forced_value;
    logic              always_lit;
    logic [LevelW-1:0] level;
  } state_t;

  typedef struct packed {
    logic              light_on;
    logic [LevelW-1:0] duty;
    logic              accepted;
  } result_t;

endpackage

// ===== src/btc_step.sv =====
// Next-state and result logic for one event beat.
`timescale 1ns / 1ps

module btc_step (
  input  btc_pkg::state_t             state_i,
  input  btc_pkg::cfg_t               cfg_i,
  input  logic [2:0]                  action_i,
  input  logic [btc_pkg::TimeW-1:0]   now_ms_i,
  input  logic                        flag_value_i,
  input  logic [btc_pkg::ReqW-1:0]    new_level_i,
  output btc_pkg::state_t             state_o,
  output btc_pkg::result_t            result_o
);
  import btc_pkg::*;

  logic [TimeW-1:0] arm_deadline;
  logic [TimeW-1:0] since;
  logic             expired;
  logic             in_range;
  logic             accepted;

  assign arm_deadline = now_ms_i + {1'b0, cfg_i.timeout};
  assign since        = now_ms_i - state_i.deadline;
  assign expired      = ~since[TimeW-1];
  assign in_range     = (new_level_i >= {1'b0, cfg_i.level_min}) &&
                        (new_level_i <= {1'b0, cfg_i.level_max});

  always_comb begin
    state_o  = state_i;
    accepted = 1'b0;
    unique case (action_i)
      ACT_TICK: begin
        priority if (state_i.forced) begin
          state_o.lit = state_i.forced_value;
        end else if (state_i.always_lit) begin
          state_o.armed = 1'b0;
          state_o.lit   = 1'b1;
        end else if (state_i.armed && expired) begin
          state_o.armed = 1'b0;
          state_o.lit   = 1'b0;
        end
      end
      ACT_ACTIVITY: begin
        state_o.forced = 1'b0;
        state_o.lit    = 1'b1;
        if (state_i.always_lit) begin
          state_o.armed = 1'b0;
        end else begin
          state_o.armed    = 1'b1;
          state_o.deadline = arm_deadline;
        end
      end
      ACT_FORCE: begin
        state_o.forced       = 1'b1;
        state_o.forced_value = flag_value_i;
        state_o.armed        = 1'b0;
        state_o.lit          = flag_value_i;
      end
      ACT_RELEASE: begin
        if (state_i.forced) begin
          state_o.forced       = 1'b0;
          state_o.forced_value = 1'b0;
          state_o.lit          = 1'b1;
          if (state_i.always_lit) begin
            state_o.armed = 1'b0;
          end else begin
            state_o.armed    = 1'b1;
            state_o.deadline = arm_deadline;
          end
        end
      end
      ACT_ALWAYS: begin
        if (state_i.always_lit != flag_value_i) begin
          state_o.always_lit = flag_value_i;
          if (!state_i.forced) begin
            if (flag_value_i) begin
              state_o.armed = 1'b0;
              state_o.lit   = 1'b1;
            end else if (state_i.lit) begin
              state_o.armed    = 1'b1;
              state_o.deadline = arm_deadline;
            end
          end
        end
      end
      ACT_LEVEL: begin
        if (in_range) begin
          state_o.level = new_level_i[LevelW-1:0];
          accepted      = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign result_o.light_on = state_o.lit;
  assign result_o.duty     = state_o.level;
  assign result_o.accepted = accepted;

endmodule

// ===== src/btc_skid.sv =====
// Output register with a skid stage for result beats.
`timescale 1ns / 1ps

module btc_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  btc_pkg::result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output btc_pkg::result_t data_o
);
  import btc_pkg::*;

  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  assign ready_o = ~skid_v_q;
  assign valid_o = out_v_q;
  assign data_o  = out_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (!out_v_q || ready_i) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = data_i;
        out_v_d = push_i;
      end
    end else if (push_i) begin
      skid_d   = data_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a beat while output stage is empty");
  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && ready_o && out_v_q && !ready_i) |=> skid_v_q)
    else $error("beat pushed during stall was not captured in skid");
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && ready_i) |=> (!skid_v_q && out_v_q && out_q == $past(skid_q)))
    else $error("skid beat did not move to output stage");
`endif

endmodule

// ===== src/backlight_timeout_controller_core.sv =====
// Top level: backlight inactivity-timeout controller core.
// Latency: a result beat is valid the cycle after its event beat is accepted
// when the output register is free; a stalled output delays it further.
// Throughput: one event per cycle unless the skid is full (in_ready_o low);
// the state update is one add, subtract and compare between state and output registers.
// A two-entry output stage (register plus skid) keeps input ready while one result waits.
// Reset (async, active low) loads the register defaults, clears all flags and
// sets the level to the default level; no clearing pass.
`timescale 1ns / 1ps

module backlight_timeout_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    action_i,
  input  logic [btc_pkg::TimeW-1:0]     now_ms_i,
  input  logic                          flag_value_i,
  input  logic [btc_pkg::ReqW-1:0]      new_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          light_on_o,
  output logic [btc_pkg::LevelW-1:0]    duty_percent_o,
  output logic                          level_accepted_o,
  input  logic                          cfg_we_i,
  input  logic [btc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [btc_pkg::TimeoutW-1:0]  cfg_data_i
);
  import btc_pkg::*;

  cfg_t              cfg_q, cfg_d;
  state_t            state_q, state_d;
  state_t            step_state;
  result_t           step_result;
  result_t           out_data;
  logic              accept;

  assign accept = in_valid_i & in_ready_o;

  btc_step u_step (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .action_i     (action_i),
    .now_ms_i     (now_ms_i),
    .flag_value_i (flag_value_i),
    .new_level_i  (new_level_i),
    .state_o      (step_state),
    .result_o     (step_result)
  );

  // writing the default level loads the live level at once
  always_comb begin
    cfg_d   = cfg_q;
    state_d = accept ? step_state : state_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TIMEOUT:       cfg_d.timeout   = cfg_data_i;
        CFG_LEVEL_MIN:     cfg_d.level_min = cfg_data_i[LevelW-1:0];
        CFG_LEVEL_MAX:     cfg_d.level_max = cfg_data_i[LevelW-1:0];
        CFG_LEVEL_DEFAULT: begin
          state_d.level = cfg_data_i[LevelW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout   <= TimeoutReset;
      cfg_q.level_min <= LevelMinReset;
      cfg_q.level_max <= LevelMaxReset;
      state_q         <= '{deadline: '0, armed: 1'b0, lit: 1'b0, forced: 1'b0,
                           forced_value: 1'b0, always_lit: 1'b0,
                           level: LevelDefaultReset};
    end else begin
      cfg_q           <= cfg_d;
      state_q         <= state_d;
    end
  end

  btc_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (step_result),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data)
  );

  assign light_on_o       = out_data.light_on;
  assign duty_percent_o   = out_data.duty;
  assign level_accepted_o = out_data.accepted;

`ifndef NO_ASSERTIONS
  a_level_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && step_result.accepted) |=> (state_q.level == $past(new_level_i[LevelW-1:0])))
    else $error("accepted level was not stored");
  a_force_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.forced && !state_q.armed && accept && action_i == ACT_TICK) |=>
    (state_q.lit == $past(state_q.forced_value)))
    else $error("tick while forced did not keep forced value");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
    (out_valid_o && $stable({light_on_o, duty_percent_o, level_accepted_o})))
    else $error("result beat changed while stalled");
`endif

endmodule
